### src/hidbp_pkg.sv
`timescale 1ns / 1ps
// hidbp_pkg: types and fixed codes shared by the HID boot descriptor parser.
// No dependencies.
package hidbp_pkg;

  // Descriptor type codes and HID boot interface codes
  localparam logic [7:0] DescTypeInterface = 8'h04;
  localparam logic [7:0] DescTypeEndpoint  = 8'h05;
  localparam logic [7:0] ClassHid          = 8'h03;
  localparam logic [7:0] SubclassBoot      = 8'h01;
  localparam logic [1:0] ProtoKeyboard     = 2'd1;
  localparam logic [1:0] ProtoMouse        = 2'd2;
  localparam logic [1:0] ProtoReset        = ProtoMouse;

  // Byte offsets inside the configuration descriptor header
  localparam int OffTotalLo  = 2;
  localparam int OffTotalHi  = 3;
  localparam int OffFirstChk = 4;
  localparam int OffConfig   = 5;

  // Byte positions inside interface and endpoint descriptors
  localparam logic [7:0] IdxIfNumber  = 8'd2;
  localparam logic [7:0] IdxIfClass   = 8'd5;
  localparam logic [7:0] IdxIfSub     = 8'd6;
  localparam logic [7:0] IdxIfProto   = 8'd7;
  localparam logic [7:0] IdxEpAddr    = 8'd2;
  localparam logic [7:0] IdxEpAttr    = 8'd3;
  localparam logic [7:0] IdxEpMpsLo   = 8'd4;
  localparam logic [7:0] IdxEpMpsHi   = 8'd5;
  localparam logic [7:0] IdxEpIntv    = 8'd6;

  localparam logic [2:0] MatchAll = 3'b111;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  device_class;
    logic [7:0]  config_value;
    logic [7:0]  interface_number;
    logic [7:0]  endpoint_address;
    logic [7:0]  endpoint_attributes;
    logic [15:0] max_packet_size;
    logic [7:0]  poll_interval;
  } result_t;

endpackage

### src/hidbp_in_reg.sv
`timescale 1ns / 1ps
// hidbp_in_reg: input register of the parser; holds one byte transfer.
// Depends on hidbp_pkg.
module hidbp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hidbp_pkg::item_t  item_i,
  input  logic              advance_i,
  output logic              valid_o,
  output hidbp_pkg::item_t  item_o
);

  logic             valid_q, valid_d;
  hidbp_pkg::item_t item_q;
  logic             load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### src/hidbp_core.sv
`timescale 1ns / 1ps
// hidbp_core: parse state and per-byte decode of the descriptor set.
// Depends on hidbp_pkg.
module hidbp_core #(
  parameter int BUFFER_BYTES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  hidbp_pkg::item_t   item_i,
  input  logic               commit_i,
  output logic               has_result_o,
  output hidbp_pkg::result_t result_o
);

  localparam int OW = $clog2(BUFFER_BYTES + 1);
  localparam logic [OW-1:0] BufLen = OW'(BUFFER_BYTES);
  localparam logic [15:0]   BufW   = 16'(BUFFER_BYTES);

  logic [1:0]    proto_q;
  logic [OW-1:0] off_q, off_d;
  logic [OW-1:0] tl_q, tl_d;
  logic [7:0]    lo_q, lo_d;
  logic [7:0]    idx_q, idx_d;
  logic [7:0]    len_q, len_d;
  logic [7:0]    type_q, type_d;
  logic [2:0]    cm_q, cm_d;
  logic          im_q, im_d;
  logic          done_q, done_d;
  logic [7:0]    cfg_q, cfg_d;
  logic [7:0]    if_q, if_d;
  logic [7:0]    ep_addr_q, ep_addr_d;
  logic [7:0]    ep_attr_q, ep_attr_d;
  logic [15:0]   ep_mps_q, ep_mps_d;
  logic [7:0]    ep_intv_q, ep_intv_d;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] raw;
    logic [8:0]  idx_inc;
    logic        res;
    logic        hit;

    b   = item_i.data_byte;
    res = 1'b0;
    hit = 1'b0;
    raw = {b, lo_q};

    // start from a fresh parse on the first byte of a set
    if (item_i.first_byte) begin
      off_d = '0;  tl_d = BufLen; lo_d = '0;  idx_d = '0;  len_d = '0;
      type_d = '0; cm_d = '0;     im_d = 1'b0; done_d = 1'b0;
      cfg_d = '0;  if_d = '0;     ep_addr_d = '0; ep_attr_d = '0;
      ep_mps_d = '0; ep_intv_d = '0;
    end else begin
      off_d = off_q;  tl_d = tl_q;  lo_d = lo_q;  idx_d = idx_q;  len_d = len_q;
      type_d = type_q; cm_d = cm_q; im_d = im_q; done_d = done_q;
      cfg_d = cfg_q;  if_d = if_q;  ep_addr_d = ep_addr_q; ep_attr_d = ep_attr_q;
      ep_mps_d = ep_mps_q; ep_intv_d = ep_intv_q;
    end
    raw = {b, lo_d};
    idx_inc = {1'b0, idx_d} + 9'd1;

    if (!done_d) begin
      if (off_d >= BufLen) begin
        res = 1'b1;
      end else begin
        if (off_d == OW'(hidbp_pkg::OffTotalLo)) begin
          lo_d = b;
        end else if (off_d == OW'(hidbp_pkg::OffTotalHi)) begin
          tl_d = (raw > BufW) ? BufLen : raw[OW-1:0];
        end else if (off_d == OW'(hidbp_pkg::OffConfig)) begin
          cfg_d = b;
        end

        if (idx_d == 8'd0) begin
          if ((off_d >= OW'(hidbp_pkg::OffFirstChk) && off_d >= tl_d) || b == 8'd0) begin
            res = 1'b1;
          end else begin
            len_d  = b;
            type_d = '0;
            cm_d   = '0;
          end
        end else if (idx_d == 8'd1) begin
          type_d = b;
        end else if (type_d == hidbp_pkg::DescTypeInterface && !im_d) begin
          if (idx_d == hidbp_pkg::IdxIfNumber) begin
            if_d = b;
          end else if (idx_d == hidbp_pkg::IdxIfClass) begin
            if (b == hidbp_pkg::ClassHid) cm_d[0] = 1'b1;
          end else if (idx_d == hidbp_pkg::IdxIfSub) begin
            if (b == hidbp_pkg::SubclassBoot) cm_d[1] = 1'b1;
          end else if (idx_d == hidbp_pkg::IdxIfProto) begin
            if (b == {6'd0, proto_q} &&
                (b == {6'd0, hidbp_pkg::ProtoKeyboard} || b == {6'd0, hidbp_pkg::ProtoMouse}))
              cm_d[2] = 1'b1;
            if (cm_d == hidbp_pkg::MatchAll) im_d = 1'b1;
          end
        end else if (type_d == hidbp_pkg::DescTypeEndpoint && im_d) begin
          if (idx_d == hidbp_pkg::IdxEpAddr) begin
            ep_addr_d = b;
          end else if (idx_d == hidbp_pkg::IdxEpAttr) begin
            ep_attr_d = b;
          end else if (idx_d == hidbp_pkg::IdxEpMpsLo) begin
            ep_mps_d[7:0] = b;
          end else if (idx_d == hidbp_pkg::IdxEpMpsHi) begin
            ep_mps_d[15:8] = b;
          end else if (idx_d == hidbp_pkg::IdxEpIntv) begin
            ep_intv_d = b;
            hit       = 1'b1;
            res       = 1'b1;
          end
        end

        // descriptors starting in the header must fit the total length;
        // at this offset the descriptor index is at most three
        if (!res && off_d == OW'(hidbp_pkg::OffTotalHi) &&
            tl_d <= OW'(2'd3 - idx_d[1:0])) begin
          res = 1'b1;
        end

        if (!res) begin
          idx_d = (idx_inc >= {1'b0, len_d}) ? 8'd0 : idx_inc[7:0];
          off_d = off_d + OW'(1);
          if (item_i.final_byte) res = 1'b1;
        end
      end
    end

    if (res) done_d = 1'b1;

    has_result_o = res;
    result_o     = '0;
    if (hit) begin
      result_o.found               = 1'b1;
      result_o.device_class        = proto_q;
      result_o.config_value        = cfg_d;
      result_o.interface_number    = if_d;
      result_o.endpoint_address    = ep_addr_d;
      result_o.endpoint_attributes = ep_attr_d;
      result_o.max_packet_size     = ep_mps_d;
      result_o.poll_interval       = ep_intv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_q <= hidbp_pkg::ProtoReset;
    end else if (cfg_we_i) begin
      proto_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q     <= '0;
      tl_q      <= BufLen;
      lo_q      <= '0;
      idx_q     <= '0;
      len_q     <= '0;
      type_q    <= '0;
      cm_q      <= '0;
      im_q      <= 1'b0;
      done_q    <= 1'b0;
      cfg_q     <= '0;
      if_q      <= '0;
      ep_addr_q <= '0;
      ep_attr_q <= '0;
      ep_mps_q  <= '0;
      ep_intv_q <= '0;
    end else if (commit_i) begin
      off_q     <= off_d;
      tl_q      <= tl_d;
      lo_q      <= lo_d;
      idx_q     <= idx_d;
      len_q     <= len_d;
      type_q    <= type_d;
      cm_q      <= cm_d;
      im_q      <= im_d;
      done_q    <= done_d;
      cfg_q     <= cfg_d;
      if_q      <= if_d;
      ep_addr_q <= ep_addr_d;
      ep_attr_q <= ep_attr_d;
      ep_mps_q  <= ep_mps_d;
      ep_intv_q <= ep_intv_d;
    end
  end

  a_done_after_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && has_result_o |=> done_q)
    else $error("parse not closed after a result");

  a_found_class : assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_result_o && result_o.found |->
      (result_o.device_class == hidbp_pkg::ProtoKeyboard ||
       result_o.device_class == hidbp_pkg::ProtoMouse))
    else $error("found result with no boot protocol");

  a_found_needs_iface : assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_result_o && result_o.found |-> im_q && !item_i.first_byte)
    else $error("endpoint reported without a matched interface");

  a_offset_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    off_q <= BufLen && tl_q <= BufLen)
    else $error("offset or total length beyond buffer");

  a_done_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !item_i.first_byte |-> !has_result_o)
    else $error("result after parse closed");

endmodule

### src/hidbp_out_reg.sv
`timescale 1ns / 1ps
// hidbp_out_reg: result register holding one result transfer until taken.
// Depends on hidbp_pkg.
module hidbp_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hidbp_pkg::result_t result_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hidbp_pkg::result_t result_o
);

  logic               valid_q, valid_d;
  hidbp_pkg::result_t result_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    if (push_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

### src/usb_hid_boot_descriptor_parser.sv
`timescale 1ns / 1ps
// usb_hid_boot_descriptor_parser: top level of the HID boot descriptor parser.
// Depends on hidbp_pkg, hidbp_in_reg, hidbp_core, hidbp_out_reg.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  data_byte_i, first_byte_i, final_byte_i
//   out      output     out_valid_o / out_stall_i found_o .. poll_interval_o
//   cfg      input      cfg_we_i                 cfg_wdata_i (wanted protocol)
//
// One byte per cycle while in_stall_o is low; a result is held in the result register.
// The input register decodes into the result register in a single pass.
// Reset clears the parse to offset 0 and sets the wanted protocol to mouse.
// A stalled result holds the input side only when the next byte makes a result.
module usb_hid_boot_descriptor_parser #(
  parameter int BUFFER_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        final_byte_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [1:0]  device_class_o,
  output logic [7:0]  config_value_o,
  output logic [7:0]  interface_number_o,
  output logic [7:0]  endpoint_address_o,
  output logic [7:0]  endpoint_attributes_o,
  output logic [15:0] max_packet_size_o,
  output logic [7:0]  poll_interval_o
);

  hidbp_pkg::item_t   in_item, held_item;
  hidbp_pkg::result_t core_result, out_result;
  logic               held_valid;
  logic               has_result;
  logic               out_ready;
  logic               advance;

  assign in_item.data_byte  = data_byte_i;
  assign in_item.first_byte = first_byte_i;
  assign in_item.final_byte = final_byte_i;

  // advance a held byte unless its result has nowhere to go
  assign advance = held_valid && (!has_result || out_ready);

  hidbp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  hidbp_core #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_i       (held_item),
    .commit_i     (advance),
    .has_result_o (has_result),
    .result_o     (core_result)
  );

  hidbp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance && has_result),
    .result_i    (core_result),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign found_o               = out_result.found;
  assign device_class_o        = out_result.device_class;
  assign config_value_o        = out_result.config_value;
  assign interface_number_o    = out_result.interface_number;
  assign endpoint_address_o    = out_result.endpoint_address;
  assign endpoint_attributes_o = out_result.endpoint_attributes;
  assign max_packet_size_o     = out_result.max_packet_size;
  assign poll_interval_o       = out_result.poll_interval;

endmodule
